### rtl/scan_device_table_assert.svh
// Assertion macros for the scan device table.
`ifndef SCAN_DEVICE_TABLE_ASSERT_SVH
`define SCAN_DEVICE_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF

`define SDT_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: label");

`define SDT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");

`define SDT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`else

`define SDT_ASSERT_ALWAYS(label, clk, rst, expr)
`define SDT_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SDT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/sdt_pkg.sv
// Constants and codes shared by the scan device table.
package sdt_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int NAME_BYTES_DEF  = 8;
  localparam int UUID_SLOTS      = 4;

  localparam int ADDR_W     = 48;
  localparam int NAME_IN_W  = 64;
  localparam int UUID_IN_W  = 64;
  localparam int UUID_W     = 16;

  localparam logic [15:0] HID_SERVICE     = 16'h1812;
  localparam logic [15:0] APPEAR_KEYBOARD = 16'h03c1;
  localparam logic [15:0] APPEAR_MOUSE    = 16'h03c2;
  localparam logic signed [7:0] RSSI_CEILING = 8'sd127;

  localparam logic [1:0] FUNC_NOTE  = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;

  localparam logic [2:0] ST_MERGED      = 3'd0;
  localparam logic [2:0] ST_APPENDED    = 3'd1;
  localparam logic [2:0] ST_REPLACED    = 3'd2;
  localparam logic [2:0] ST_DROPPED     = 3'd3;
  localparam logic [2:0] ST_CLEARED     = 3'd4;
  localparam logic [2:0] ST_READ_OK     = 3'd5;
  localparam logic [2:0] ST_READ_BEYOND = 3'd6;

endpackage

### rtl/scan_device_table.sv
// Scan device table: advertiser table in one memory, walked one entry per cycle.
// A clear, or a read beyond the count, goes from IDLE straight to DONE; a read in
//   range passes READ first; an advertisement walks the used entries in SCAN, then
//   DECIDE, unless a match ends the walk and goes to DONE. A new word is taken only
//   once the last result is loaded out; the single read port scans one entry a cycle.
// Reset clears the entry count, handshake and control state; table contents are
//   left as they are and no clearing pass runs.
`include "scan_device_table_assert.svh"

module scan_device_table #(
  parameter int TABLE_DEPTH = sdt_pkg::TABLE_DEPTH_DEF,
  parameter int NAME_BYTES  = sdt_pkg::NAME_BYTES_DEF,
  localparam int IDX_W = $clog2(TABLE_DEPTH),
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     func,
  input  logic [sdt_pkg::ADDR_W-1:0]     adv_addr,
  input  logic [1:0]                     adv_addr_type,
  input  logic signed [7:0]              adv_rssi,
  input  logic [sdt_pkg::NAME_IN_W-1:0]  adv_name,
  input  logic                           appearance_present,
  input  logic [15:0]                    appearance_code,
  input  logic [2:0]                     uuid_count,
  input  logic [sdt_pkg::UUID_IN_W-1:0]  uuid_list,
  input  logic [IDX_W-1:0]               entry_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     status,
  output logic [IDX_W-1:0]               slot,
  output logic [CNT_W-1:0]               entry_count,
  output logic [sdt_pkg::ADDR_W-1:0]     out_addr,
  output logic [1:0]                     out_addr_type,
  output logic signed [7:0]              out_rssi,
  output logic [sdt_pkg::NAME_IN_W-1:0]  out_name,
  output logic                           out_hid
);

  localparam int NAME_W = 8 * NAME_BYTES;

  typedef struct packed {
    logic [sdt_pkg::ADDR_W-1:0] addr;
    logic [1:0]                 addr_kind;
    logic [7:0]                 rssi;
    logic [NAME_W-1:0]          name;
    logic                       hid;
  } entry_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [IDX_W-1:0] slot;
    logic [CNT_W-1:0] count;
    entry_t           ent;
  } result_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_READ   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  function automatic logic [NAME_W-1:0] clean_name(input logic [sdt_pkg::NAME_IN_W-1:0] raw);
    logic [NAME_W-1:0] kept;
    logic              live;
    kept = '0;
    live = 1'b1;
    for (int b = 0; b < NAME_BYTES; b++) begin
      live = live && (raw[8*b +: 8] != 8'd0);
      if (live) kept[8*b +: 8] = raw[8*b +: 8];
    end
    return kept;
  endfunction

  function automatic logic input_device(input logic                          app_ok,
                                        input logic [15:0]                   app,
                                        input logic [2:0]                    cnt,
                                        input logic [sdt_pkg::UUID_IN_W-1:0] list);
    logic hit;
    hit = app_ok && (app == sdt_pkg::APPEAR_KEYBOARD || app == sdt_pkg::APPEAR_MOUSE);
    for (int i = 0; i < sdt_pkg::UUID_SLOTS; i++) begin
      if (3'(i) < cnt && list[sdt_pkg::UUID_W*i +: sdt_pkg::UUID_W] == sdt_pkg::HID_SERVICE)
        hit = 1'b1;
    end
    return hit;
  endfunction

  state_t            state;
  logic [CNT_W-1:0]  used_count;
  entry_t            new_ent;
  logic [CNT_W-1:0]  rd_ptr;
  logic              rd_vld;
  logic [IDX_W-1:0]  chk_idx;
  logic signed [7:0] worst;
  logic [IDX_W-1:0]  pick;
  logic              found;
  result_t           res;

  entry_t            mem [TABLE_DEPTH];
  entry_t            rd_data;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;

  logic              in_fire;
  logic              idx_in_range;
  logic              match;
  logic              room;
  logic              do_replace;
  logic              candidate;
  logic              load_out;
  entry_t            merged;

  assign in_stall     = rst || (state != S_IDLE);
  assign in_fire      = in_valid && !in_stall;
  assign idx_in_range = CNT_W'(entry_index) < used_count;
  assign match        = (state == S_SCAN) && rd_vld && (rd_data.addr == new_ent.addr);
  assign room         = used_count < CNT_W'(TABLE_DEPTH);
  assign do_replace   = found && (new_ent.hid || new_ent.name[7:0] != 8'd0);
  assign load_out     = (state == S_DONE) && (!out_valid || !out_stall);
  // entries with neither a name nor the input-device mark may be evicted
  assign candidate    = !rd_data.hid && rd_data.name[7:0] == 8'd0 &&
                        $signed(rd_data.rssi) <= worst;

  always_comb begin
    merged      = rd_data;
    merged.rssi = new_ent.rssi;
    merged.hid  = rd_data.hid | new_ent.hid;
    if (rd_data.name[7:0] == 8'd0 && new_ent.name[7:0] != 8'd0) merged.name = new_ent.name;
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = rd_ptr[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = used_count[IDX_W-1:0];
    wr_data = new_ent;
    case (state)
      S_IDLE: begin
        if (in_fire && func != sdt_pkg::FUNC_NOTE && func != sdt_pkg::FUNC_CLEAR &&
            idx_in_range) begin
          rd_en   = 1'b1;
          rd_addr = entry_index;
        end
      end
      S_SCAN: begin
        rd_en = rd_ptr < used_count;
        if (match) begin
          wr_en   = 1'b1;
          wr_addr = chk_idx;
          wr_data = merged;
        end
      end
      S_DECIDE: begin
        if (room) begin
          wr_en = 1'b1;
        end else if (do_replace) begin
          wr_en   = 1'b1;
          wr_addr = pick;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used_count <= '0;
      rd_vld     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            new_ent.addr      <= adv_addr;
            new_ent.addr_kind <= adv_addr_type;
            new_ent.rssi      <= adv_rssi;
            new_ent.name      <= clean_name(adv_name);
            new_ent.hid       <= input_device(appearance_present, appearance_code,
                                              uuid_count, uuid_list);
            case (func)
              sdt_pkg::FUNC_CLEAR: begin
                used_count <= '0;
                res        <= '{sdt_pkg::ST_CLEARED, '0, '0, '0};
                state      <= S_DONE;
              end
              sdt_pkg::FUNC_NOTE: begin
                rd_ptr <= '0;
                rd_vld <= 1'b0;
                worst  <= sdt_pkg::RSSI_CEILING;
                found  <= 1'b0;
                pick   <= '0;
                state  <= (used_count == '0) ? S_DECIDE : S_SCAN;
              end
              default: begin
                // func 3 reads as well
                if (idx_in_range) begin
                  res.slot  <= entry_index;
                  res.count <= used_count;
                  state     <= S_READ;
                end else begin
                  res   <= '{sdt_pkg::ST_READ_BEYOND, entry_index, used_count, '0};
                  state <= S_DONE;
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          // no read is in flight past the last entry, and a match ends the walk
          rd_vld  <= rd_en && !match;
          chk_idx <= rd_ptr[IDX_W-1:0];
          if (rd_en) rd_ptr <= rd_ptr + CNT_W'(1);
          if (rd_vld) begin
            if (match) begin
              res   <= '{sdt_pkg::ST_MERGED, chk_idx, used_count, '0};
              state <= S_DONE;
            end else begin
              if (candidate) begin
                worst <= $signed(rd_data.rssi);
                pick  <= chk_idx;
                found <= 1'b1;
              end
              if (CNT_W'(chk_idx) + CNT_W'(1) == used_count) begin
                state <= S_DECIDE;
              end
            end
          end
        end
        S_DECIDE: begin
          if (room) begin
            res <= '{sdt_pkg::ST_APPENDED, used_count[IDX_W-1:0],
                     used_count + CNT_W'(1), '0};
            used_count <= used_count + CNT_W'(1);
          end else if (do_replace) begin
            res <= '{sdt_pkg::ST_REPLACED, pick, used_count, '0};
          end else begin
            res <= '{sdt_pkg::ST_DROPPED, '0, used_count, '0};
          end
          state <= S_DONE;
        end
        S_READ: begin
          res.status <= sdt_pkg::ST_READ_OK;
          res.ent    <= rd_data;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result word register, loaded as the pending result leaves
  always_ff @(posedge clk) begin
    if (load_out) begin
      status        <= res.status;
      slot          <= res.slot;
      entry_count   <= res.count;
      out_addr      <= res.ent.addr;
      out_addr_type <= res.ent.addr_kind;
      out_rssi      <= res.ent.rssi;
      out_name      <= sdt_pkg::NAME_IN_W'(res.ent.name);
      out_hid       <= res.ent.hid;
    end
  end

  `SDT_ASSERT_ALWAYS(a_count_bound, clk, rst, used_count <= CNT_W'(TABLE_DEPTH))
  `SDT_ASSERT_IMPLY(a_write_phase, clk, rst, wr_en, (state == S_SCAN || state == S_DECIDE))
  `SDT_ASSERT_NEXT(a_count_hold, clk, rst, (state != S_DECIDE && !(in_fire && func == sdt_pkg::FUNC_CLEAR)), $stable(used_count))
  `SDT_ASSERT_IMPLY(a_check_range, clk, rst, (state == S_SCAN && rd_vld), CNT_W'(chk_idx) < used_count)
  `SDT_ASSERT_NEXT(a_done_loads, clk, rst, (state == S_DONE && !(out_valid && out_stall)), (out_valid && state == S_IDLE))

endmodule

### bench/tb.sv
// Self-checking bench for scan_device_table: directed table cases, then random words.
module tb;

  localparam logic [1:0] FUNC_READ     = 2'd2;
  localparam logic [1:0] FUNC_READ_ALT = 2'd3;
  localparam int         DEPTH         = 16;
  localparam int         POOL_SIZE     = 20;
  localparam int         RANDOM_WORDS  = 1200;
  localparam int         IDLE_LIMIT    = 4000;
  localparam int         TAIL_CYCLES   = 25;

  typedef struct packed {
    logic [1:0]  func;
    logic [47:0] addr;
    logic [1:0]  addr_kind;
    logic [7:0]  rssi;
    logic [63:0] name;
    logic        app_present;
    logic [15:0] app_code;
    logic [2:0]  uuid_count;
    logic [63:0] uuid_list;
    logic [3:0]  entry_index;
  } adv_word_t;

  // field order matches the output port order used by the monitor
  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [4:0]  count;
    logic [47:0] addr;
    logic [1:0]  addr_kind;
    logic [7:0]  rssi;
    logic [63:0] name;
    logic        hid;
  } table_result_t;

  class word_scoreboard;
    table_result_t       due_q[$];
    int                  fail_count;
    logic [4:0]          used;
    logic [47:0]         addr_mem[DEPTH];
    logic [1:0]          type_mem[DEPTH];
    logic signed [7:0]   rssi_mem[DEPTH];
    logic [63:0]         name_mem[DEPTH];
    logic                hid_mem[DEPTH];

    function new();
      fail_count = 0;
      used = '0;
    endfunction

    function void report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      fail_count++;
    endfunction

    function void store_entry(int s, adv_word_t w, logic [63:0] nm, logic hid);
      addr_mem[s] = w.addr;
      type_mem[s] = w.addr_kind;
      rssi_mem[s] = w.rssi;
      name_mem[s] = nm;
      hid_mem[s]  = hid;
    endfunction

    // predicts the result word of one accepted input word
    function void note_word(adv_word_t w);
      table_result_t r;
      logic [63:0]   nm;
      logic          hid;
      logic          hit;
      logic          found;
      int            worst;
      int            pick;
      int            cnt;
      r = '0;
      case (w.func)
        sdt_pkg::FUNC_CLEAR: begin
          used = '0;
          r.status = sdt_pkg::ST_CLEARED;
        end
        sdt_pkg::FUNC_NOTE: begin
          nm = '0;
          for (int b = 0; b < 8; b++) begin
            if (w.name[8*b +: 8] == 8'h00) break;
            nm[8*b +: 8] = w.name[8*b +: 8];
          end
          hid = w.app_present &&
                (w.app_code == sdt_pkg::APPEAR_KEYBOARD || w.app_code == sdt_pkg::APPEAR_MOUSE);
          cnt = (w.uuid_count > 3'd4) ? 4 : int'(w.uuid_count);
          for (int i = 0; i < cnt; i++)
            if (w.uuid_list[16*i +: 16] == sdt_pkg::HID_SERVICE) hid = 1'b1;
          hit = 1'b0;
          for (int i = 0; i < used && !hit; i++) begin
            if (addr_mem[i] == w.addr) begin
              // merge: address type stays, name only filled when empty
              if (name_mem[i][7:0] == 8'h00 && nm[7:0] != 8'h00) name_mem[i] = nm;
              rssi_mem[i] = w.rssi;
              if (hid) hid_mem[i] = 1'b1;
              r.status = sdt_pkg::ST_MERGED;
              r.slot = i[3:0];
              hit = 1'b1;
            end
          end
          if (!hit) begin
            if (used < DEPTH) begin
              store_entry(used, w, nm, hid);
              r.status = sdt_pkg::ST_APPENDED;
              r.slot = used[3:0];
              used++;
            end else begin
              worst = 127;
              found = 1'b0;
              pick = 0;
              // weakest plain entry, last one on ties
              for (int i = 0; i < DEPTH; i++) begin
                if (!hid_mem[i] && name_mem[i][7:0] == 8'h00 && rssi_mem[i] <= worst) begin
                  worst = rssi_mem[i];
                  pick = i;
                  found = 1'b1;
                end
              end
              if (found && (hid || nm[7:0] != 8'h00)) begin
                store_entry(pick, w, nm, hid);
                r.status = sdt_pkg::ST_REPLACED;
                r.slot = pick[3:0];
              end else begin
                r.status = sdt_pkg::ST_DROPPED;
              end
            end
          end
        end
        default: begin
          r.slot = w.entry_index;
          if (w.entry_index < used) begin
            r.status = sdt_pkg::ST_READ_OK;
            r.addr = addr_mem[w.entry_index];
            r.addr_kind = type_mem[w.entry_index];
            r.rssi = rssi_mem[w.entry_index];
            r.name = name_mem[w.entry_index];
            r.hid = hid_mem[w.entry_index];
          end else begin
            r.status = sdt_pkg::ST_READ_BEYOND;
          end
        end
      endcase
      r.count = used;
      due_q.push_back(r);
    endfunction

    function void check_field(string fname, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %0h, expected %0h", fname, got, want));
    endfunction

    function void check_word(table_result_t got);
      table_result_t want;
      if (due_q.size() == 0) begin
        report_mismatch("result word with nothing outstanding");
      end else begin
        want = due_q.pop_front();
        check_field("status", got.status, want.status);
        check_field("slot", got.slot, want.slot);
        check_field("entry_count", got.count, want.count);
        check_field("out_addr", got.addr, want.addr);
        check_field("out_addr_type", got.addr_kind, want.addr_kind);
        check_field("out_rssi", got.rssi, want.rssi);
        check_field("out_name", got.name, want.name);
        check_field("out_hid", got.hid, want.hid);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         func = '0;
  logic [47:0]        adv_addr = '0;
  logic [1:0]         adv_addr_type = '0;
  logic signed [7:0]  adv_rssi = '0;
  logic [63:0]        adv_name = '0;
  logic               appearance_present = 1'b0;
  logic [15:0]        appearance_code = '0;
  logic [2:0]         uuid_count = '0;
  logic [63:0]        uuid_list = '0;
  logic [3:0]         entry_index = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         status;
  logic [3:0]         slot;
  logic [4:0]         entry_count;
  logic [47:0]        out_addr;
  logic [1:0]         out_addr_type;
  logic signed [7:0]  out_rssi;
  logic [63:0]        out_name;
  logic               out_hid;

  bit                 calm = 1'b0;
  logic [47:0]        addr_pool[POOL_SIZE];
  word_scoreboard     sb = new();

  scan_device_table dut (
    .clk, .rst, .in_valid, .in_stall, .func, .adv_addr, .adv_addr_type, .adv_rssi,
    .adv_name, .appearance_present, .appearance_code, .uuid_count, .uuid_list,
    .entry_index, .out_valid, .out_stall, .status, .slot, .entry_count, .out_addr,
    .out_addr_type, .out_rssi, .out_name, .out_hid
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 38);
  endfunction

  function automatic adv_word_t make_note(logic [47:0] a, logic [1:0] t, logic [7:0] r,
                                          logic [63:0] nm, logic ap, logic [15:0] ac,
                                          logic [2:0] uc, logic [63:0] ul);
    adv_word_t w;
    w = '0;
    w.func = sdt_pkg::FUNC_NOTE;
    w.addr = a;
    w.addr_kind = t;
    w.rssi = r;
    w.name = nm;
    w.app_present = ap;
    w.app_code = ac;
    w.uuid_count = uc;
    w.uuid_list = ul;
    w.entry_index = 4'($urandom);
    return w;
  endfunction

  function automatic adv_word_t make_cmd(logic [1:0] f, logic [3:0] idx);
    adv_word_t w;
    w = make_note(48'($urandom), 2'($urandom), 8'($urandom), {$urandom, $urandom},
                  1'($urandom), 16'($urandom), 3'($urandom), {$urandom, $urandom});
    w.func = f;
    w.entry_index = idx;
    return w;
  endfunction

  function automatic adv_word_t random_word();
    adv_word_t   w;
    logic [63:0] nm;
    logic [63:0] ul;
    logic [47:0] a;
    logic [15:0] ac;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 2) return make_cmd(sdt_pkg::FUNC_CLEAR, 4'($urandom));
    if (pick < 20) return make_cmd($urandom_range(1) ? FUNC_READ : FUNC_READ_ALT, 4'($urandom));
    a = ($urandom_range(99) < 85) ? addr_pool[$urandom_range(POOL_SIZE - 1)]
                                  : 48'({$urandom, $urandom});
    nm = {$urandom, $urandom};
    case ($urandom_range(9))
      0, 1, 2, 3: nm[7:0] = 8'h00;
      4, 5, 6: ;
      default: nm[8*$urandom_range(1, 7) +: 8] = 8'h00;
    endcase
    ul = {$urandom, $urandom};
    if ($urandom_range(99) < 30) ul[16*$urandom_range(3) +: 16] = sdt_pkg::HID_SERVICE;
    case ($urandom_range(3))
      0: ac = sdt_pkg::APPEAR_KEYBOARD;
      1: ac = sdt_pkg::APPEAR_MOUSE;
      default: ac = 16'($urandom);
    endcase
    w = make_note(a, 2'($urandom), 8'($urandom), nm, 1'($urandom), ac, 3'($urandom), ul);
    return w;
  endfunction

  task automatic send_word(input adv_word_t w);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    func <= w.func;
    adv_addr <= w.addr;
    adv_addr_type <= w.addr_kind;
    adv_rssi <= w.rssi;
    adv_name <= w.name;
    appearance_present <= w.app_present;
    appearance_code <= w.app_code;
    uuid_count <= w.uuid_count;
    uuid_list <= w.uuid_list;
    entry_index <= w.entry_index;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(w);
  endtask

  task automatic drain_table();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.due_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        sb.check_word({status, slot, entry_count, out_addr, out_addr_type, out_rssi,
                       out_name, out_hid});
      out_stall <= take_break();
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("scan_device_table verification failed");
    $finish;
  end

  initial begin : stimulus
    for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = 48'({$urandom, $urandom});
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table
    send_word(make_cmd(FUNC_READ, 4'd0));
    send_word(make_cmd(sdt_pkg::FUNC_CLEAR, 4'd0));
    // extremes: all-ones address and name, keyboard appearance
    send_word(make_note('1, 2'd3, 8'sd127, '1, 1'b1, sdt_pkg::APPEAR_KEYBOARD, 3'd0, '0));
    send_word(make_note('0, 2'd0, -8'sd128, '0, 1'b0, 16'h0000, 3'd0, '0));
    // merge: name fill stops at the zero byte, type kept, id count clamped to four
    send_word(make_note('0, 2'd2, 8'sd5, 64'hFF00_0000_0000_4241, 1'b0,
                        sdt_pkg::APPEAR_MOUSE, 3'd7, {sdt_pkg::HID_SERVICE, 48'h0}));
    send_word(make_cmd(FUNC_READ, 4'd1));
    send_word(make_cmd(FUNC_READ_ALT, 4'd0));
    // service id beyond the count is ignored
    send_word(make_note(48'h1, 2'd1, -8'sd20, '0, 1'b0, 16'h0000, 3'd3,
                        {sdt_pkg::HID_SERVICE, 16'h1234, 16'h5678, 16'h9abc}));
    send_word(make_note(48'h2, 2'd0, -8'sd30, '0, 1'b1, sdt_pkg::APPEAR_MOUSE, 3'd0, '0));
    // fill up with plain entries; two tie for weakest
    for (int k = 4; k < DEPTH; k++)
      send_word(make_note(48'hA5A5_0000_0000 | 48'(k), 2'(k),
                          (k == 6 || k == 11) ? -8'sd100 : -8'sd50, '0, 1'b0,
                          sdt_pkg::APPEAR_KEYBOARD, 3'd1, 64'h1811));
    send_word(make_note(48'h3, 2'd1, -8'sd10, '0, 1'b0, 16'h0000, 3'd0, '0));
    send_word(make_note(48'h4, 2'd2, -8'sd70, 64'h0043, 1'b0, 16'h0000, 3'd0, '0));
    send_word(make_note(48'h5, 2'd3, -8'sd75, '0, 1'b0, 16'h0000, 3'd2,
                        {32'h0, sdt_pkg::HID_SERVICE, 16'h0}));
    send_word(make_cmd(FUNC_READ, 4'd11));
    send_word(make_note(48'h1, 2'd3, 8'sd99, 64'h4444, 1'b1, sdt_pkg::APPEAR_KEYBOARD,
                        3'd0, '0));
    send_word(make_cmd(sdt_pkg::FUNC_CLEAR, 4'd0));
    send_word(make_cmd(FUNC_READ, 4'd0));

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      calm = (n >= 300 && n < 500);
      if (n == 700 || $urandom_range(149) == 0) drain_table();
      send_word(random_word());
    end
    calm = 1'b0;
    drain_table();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.fail_count == 0)
      $display("scan_device_table verification clean");
    else
      $display("scan_device_table verification failed");
    $finish;
  end
endmodule
